[src/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, operation and status codes and helpers for the allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int AMT_W  = 16;
   localparam int VAL_W  = 18;
   localparam int OP_W   = 3;
   localparam int PIDX_W = 4;
   localparam int STAT_W = 3;
   localparam int CSR_W  = 5;
   localparam int AR_W   = 3;
   localparam int AP_W   = 5;

   localparam logic [VAL_W:0] VAL_MAX = 19'h3FFFF;

   localparam logic [OP_W-1:0] OP_REQUEST = 3'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
   localparam logic [OP_W-1:0] OP_PROBE   = 3'd2;
   localparam logic [OP_W-1:0] OP_NEED    = 3'd3;
   localparam logic [OP_W-1:0] OP_AVAIL   = 3'd4;
   localparam logic [OP_W-1:0] OP_MARK    = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_PROC   = 3'd1;
   localparam logic [STAT_W-1:0] ST_OVER_NEED  = 3'd2;
   localparam logic [STAT_W-1:0] ST_OVER_AVAIL = 3'd3;
   localparam logic [STAT_W-1:0] ST_UNSAFE     = 3'd4;
   localparam logic [STAT_W-1:0] ST_OVER_ALLOC = 3'd5;

   localparam logic CSR_RESOURCES = 1'b0;
   localparam logic CSR_PROCESSES = 1'b1;

   typedef logic [VAL_W-1:0] val_type;
   typedef logic [AMT_W-1:0] amt_type;

   function automatic val_type sat_add(input val_type a, input amt_type b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + {3'b000, b};
      return (s > VAL_MAX) ? VAL_MAX[VAL_W-1:0] : s[VAL_W-1:0];
   endfunction

endpackage

[src/bsa_if.sv]
// ----------------------------------------------------------------------------
// bsa channels
// Valid/ready request and response channels of the allocator.
// ----------------------------------------------------------------------------
interface bsa_req_if;
   import bsa_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [PIDX_W-1:0]   process_index;
   logic [AMT_W-1:0]    amount_0;
   logic [AMT_W-1:0]    amount_1;
   logic [AMT_W-1:0]    amount_2;
   logic [AMT_W-1:0]    amount_3;
   modport source (output valid, operation, process_index, amount_0, amount_1, amount_2,
                   amount_3, input ready);
   modport sink   (input valid, operation, process_index, amount_0, amount_1, amount_2,
                   amount_3, output ready);
endinterface

interface bsa_rsp_if;
   import bsa_pkg::*;
   logic              valid;
   logic              ready;
   logic              granted;
   logic [STAT_W-1:0] status;
   modport source (output valid, granted, status, input ready);
   modport sink   (input valid, granted, status, output ready);
endinterface

[src/bsa_row_mem.sv]
// ----------------------------------------------------------------------------
// bsa_row_mem
// One row per process slot, registered read, rows read as zero until written.
// ----------------------------------------------------------------------------
module bsa_row_mem #(
   parameter int DEPTH = 16,
   parameter int ROW_W = 72,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [ROW_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [ROW_W-1:0] rd_data
);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bankers_safety_allocator.sv]
// ----------------------------------------------------------------------------
// bankers_safety_allocator: one item at a time; loads and rejects go check, response
// request: check, scan, commit, response; release: check, commit, response; probe:
// check, scan, response; each scan visits every active process in order, skipping
// finished ones and evaluating unfinished ones; scans repeat while any process finishes
// both tables share one read address; config resets to 4 resources and 0 processes
// reset (synchronous) clears tables, available and completion marks and resets config
// ----------------------------------------------------------------------------
module bankers_safety_allocator #(
   parameter int MAX_PROC = 16,
   parameter int NUM_RES  = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   bsa_req_if.sink                   req_bus,
   bsa_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [bsa_pkg::CSR_W-1:0] csr_write_data
);
   import bsa_pkg::*;

   localparam int PW     = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
   localparam int CW     = $clog2(MAX_PROC + 1);
   localparam int WORK_W = VAL_W + $clog2(MAX_PROC + 1) + 2;
   localparam int ROW_W  = NUM_RES * VAL_W;
   localparam logic [7:0] MAXP8 = 8'(MAX_PROC);
   localparam logic [AR_W-1:0] NRES = AR_W'(NUM_RES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHK    = 3'd1;
   localparam logic [2:0] S_SRD    = 3'd2;
   localparam logic [2:0] S_SEV    = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   typedef logic signed [WORK_W-1:0] work_type;

   function automatic work_type ext_val(input val_type x);
      return work_type'({{(WORK_W-VAL_W){1'b0}}, x});
   endfunction

   function automatic work_type ext_amt(input amt_type x);
      return work_type'({{(WORK_W-AMT_W){1'b0}}, x});
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [PIDX_W-1:0]   p_ff, p_in;
   amt_type             amt_ff [NUM_RES];
   amt_type             amt_in [NUM_RES];
   val_type             avail_ff [NUM_RES];
   val_type             avail_in [NUM_RES];
   val_type             need_p_ff [NUM_RES];
   val_type             need_p_in [NUM_RES];
   val_type             alloc_p_ff [NUM_RES];
   val_type             alloc_p_in [NUM_RES];
   work_type            tn_need_ff [NUM_RES];
   work_type            tn_need_in [NUM_RES];
   work_type            tn_alloc_ff [NUM_RES];
   work_type            tn_alloc_in [NUM_RES];
   work_type            work_ff [NUM_RES];
   work_type            work_in [NUM_RES];
   logic [MAX_PROC-1:0] fin_ff, fin_in;
   logic [MAX_PROC-1:0] comp_ff, comp_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                prog_ff, prog_in;
   logic                granted_ff, granted_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [AR_W-1:0]     ar_ff, ar_in;
   logic [AP_W-1:0]     ap_ff, ap_in;

   logic                mem_rd_en;
   logic [PW-1:0]       mem_rd_addr;
   logic                need_wr_en, alloc_wr_en;
   logic [ROW_W-1:0]    need_wr_data, alloc_wr_data;
   logic [ROW_W-1:0]    need_rd, alloc_rd;

   amt_type             amt_bus [4];
   logic [AR_W-1:0]     nr;
   logic [7:0]          np8, p8, scan8;
   logic [MAX_PROC-1:0] act_mask;
   logic                safe, apply_p, accept;

   bsa_row_mem #(.DEPTH(MAX_PROC), .ROW_W(ROW_W), .AW(PW)) u_need_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (need_wr_en),
      .wr_addr (p8[PW-1:0]),
      .wr_data (need_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (need_rd)
   );

   bsa_row_mem #(.DEPTH(MAX_PROC), .ROW_W(ROW_W), .AW(PW)) u_alloc_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (alloc_wr_en),
      .wr_addr (p8[PW-1:0]),
      .wr_data (alloc_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (alloc_rd)
   );

   assign amt_bus[0] = req_bus.amount_0;
   assign amt_bus[1] = req_bus.amount_1;
   assign amt_bus[2] = req_bus.amount_2;
   assign amt_bus[3] = req_bus.amount_3;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid   = (state_ff == S_RESP);
   assign rsp_bus.granted = granted_ff;
   assign rsp_bus.status  = status_ff;

   assign nr    = (ar_ff > NRES) ? NRES : ar_ff;
   assign np8   = ({3'b000, ap_ff} > MAXP8) ? MAXP8 : {3'b000, ap_ff};
   assign p8    = {4'b0000, p_ff};
   assign scan8 = 8'(scan_ff);
   assign apply_p = (op_ff == OP_REQUEST) || ((op_ff == OP_PROBE) && (p8 < MAXP8));

   always_comb begin
      for (int k = 0; k < MAX_PROC; k++) begin
         act_mask[k] = (8'(k) < np8);
      end
   end
   assign safe = &(fin_ff | ~act_mask);

   // config registers
   always_comb begin
      ar_in = ar_ff;
      ap_in = ap_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RESOURCES: ar_in = csr_write_data[AR_W-1:0];
            CSR_PROCESSES: ap_in = csr_write_data[AP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic    fail;
      logic    fits;
      work_type needv;
      work_type allocv;
      val_type nrow;
      val_type arow;

      state_in   = state_ff;
      op_in      = op_ff;
      p_in       = p_ff;
      amt_in     = amt_ff;
      avail_in   = avail_ff;
      need_p_in  = need_p_ff;
      alloc_p_in = alloc_p_ff;
      tn_need_in = tn_need_ff;
      tn_alloc_in = tn_alloc_ff;
      work_in    = work_ff;
      fin_in     = fin_ff;
      comp_in    = comp_ff;
      scan_in    = scan_ff;
      prog_in    = prog_ff;
      granted_in = granted_ff;
      status_in  = status_ff;
      mem_rd_en  = 1'b0;
      mem_rd_addr = scan_ff[PW-1:0];
      need_wr_en = 1'b0;
      alloc_wr_en = 1'b0;
      need_wr_data = need_rd;
      alloc_wr_data = alloc_rd;
      fail = 1'b0;
      fits = 1'b1;
      needv = '0;
      allocv = '0;
      nrow = '0;
      arow = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_bus.operation;
               p_in  = req_bus.process_index;
               for (int j = 0; j < NUM_RES; j++) begin
                  amt_in[j] = amt_bus[j];
               end
               mem_rd_en   = 1'b1;
               mem_rd_addr = PW'(req_bus.process_index);
               state_in    = S_CHK;
            end
         end
         S_CHK: begin
            granted_in = 1'b0;
            status_in  = ST_OK;
            state_in   = S_RESP;
            for (int j = 0; j < NUM_RES; j++) begin
               need_p_in[j]  = need_rd[j*VAL_W +: VAL_W];
               alloc_p_in[j] = alloc_rd[j*VAL_W +: VAL_W];
               tn_need_in[j] = ext_val(need_rd[j*VAL_W +: VAL_W]) - ext_amt(amt_ff[j]);
               tn_alloc_in[j] = (op_ff == OP_REQUEST) ?
                  ext_val(sat_add(alloc_rd[j*VAL_W +: VAL_W], amt_ff[j])) :
                  ext_val(alloc_rd[j*VAL_W +: VAL_W]) + ext_amt(amt_ff[j]);
            end
            case (op_ff)
               OP_REQUEST: begin
                  if (p8 >= np8) begin
                     status_in = ST_BAD_PROC;
                  end else begin
                     for (int j = 0; j < NUM_RES; j++) begin
                        if ((AR_W'(j) < nr) &&
                            ({2'b00, amt_ff[j]} > need_rd[j*VAL_W +: VAL_W])) begin
                           fail = 1'b1;
                        end
                     end
                     if (fail) begin
                        status_in = ST_OVER_NEED;
                     end else begin
                        for (int j = 0; j < NUM_RES; j++) begin
                           if ((AR_W'(j) < nr) && ({2'b00, amt_ff[j]} > avail_ff[j])) begin
                              fail = 1'b1;
                           end
                        end
                        if (fail) begin
                           status_in = ST_OVER_AVAIL;
                        end else begin
                           state_in = S_SRD;
                        end
                     end
                  end
               end
               OP_RELEASE: begin
                  if (p8 >= np8) begin
                     status_in = ST_BAD_PROC;
                  end else begin
                     for (int j = 0; j < NUM_RES; j++) begin
                        if ((AR_W'(j) < nr) &&
                            ({2'b00, amt_ff[j]} > alloc_rd[j*VAL_W +: VAL_W])) begin
                           fail = 1'b1;
                        end
                     end
                     if (fail) begin
                        status_in = ST_OVER_ALLOC;
                     end else begin
                        state_in = S_COMMIT;
                     end
                  end
               end
               OP_PROBE: begin
                  state_in = S_SRD;
               end
               OP_NEED: begin
                  if (p8 >= MAXP8) begin
                     status_in = ST_BAD_PROC;
                  end else begin
                     need_wr_en = 1'b1;
                     for (int j = 0; j < NUM_RES; j++) begin
                        need_wr_data[j*VAL_W +: VAL_W] = {2'b00, amt_ff[j]};
                     end
                     granted_in = 1'b1;
                  end
               end
               OP_AVAIL: begin
                  for (int j = 0; j < NUM_RES; j++) begin
                     avail_in[j] = {2'b00, amt_ff[j]};
                  end
                  granted_in = 1'b1;
               end
               OP_MARK: begin
                  if (p8 >= MAXP8) begin
                     status_in = ST_BAD_PROC;
                  end else begin
                     comp_in[p8[PW-1:0]] = 1'b1;
                     granted_in = 1'b1;
                  end
               end
               default: ;
            endcase
            // safety pass starts from the tentative available copy
            for (int j = 0; j < NUM_RES; j++) begin
               work_in[j] = ext_val(avail_ff[j]) - ext_amt(amt_ff[j]);
            end
            fin_in  = comp_ff;
            scan_in = '0;
            prog_in = 1'b0;
         end
         S_SRD: begin
            if (scan8 == np8) begin
               if (prog_ff) begin
                  scan_in = '0;
                  prog_in = 1'b0;
               end else if (safe) begin
                  granted_in = 1'b1;
                  status_in  = ST_OK;
                  state_in   = (op_ff == OP_REQUEST) ? S_COMMIT : S_RESP;
               end else begin
                  granted_in = 1'b0;
                  status_in  = ST_UNSAFE;
                  state_in   = S_RESP;
               end
            end else if (fin_ff[scan_ff[PW-1:0]]) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_SEV;
            end
         end
         S_SEV: begin
            for (int j = 0; j < NUM_RES; j++) begin
               needv = (apply_p && (scan8 == p8)) ? tn_need_ff[j] :
                       ext_val(need_rd[j*VAL_W +: VAL_W]);
               if ((AR_W'(j) < nr) && (needv > work_ff[j])) begin
                  fits = 1'b0;
               end
            end
            if (fits) begin
               for (int j = 0; j < NUM_RES; j++) begin
                  allocv = (apply_p && (scan8 == p8)) ? tn_alloc_ff[j] :
                           ext_val(alloc_rd[j*VAL_W +: VAL_W]);
                  if (AR_W'(j) < nr) begin
                     work_in[j] = work_ff[j] + allocv;
                  end
               end
               fin_in[scan_ff[PW-1:0]] = 1'b1;
               prog_in = 1'b1;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = S_SRD;
         end
         S_COMMIT: begin
            need_wr_en  = 1'b1;
            alloc_wr_en = 1'b1;
            for (int j = 0; j < NUM_RES; j++) begin
               nrow = need_p_ff[j];
               arow = alloc_p_ff[j];
               if (AR_W'(j) < nr) begin
                  if (op_ff == OP_REQUEST) begin
                     avail_in[j] = avail_ff[j] - {2'b00, amt_ff[j]};
                     nrow = need_p_ff[j] - {2'b00, amt_ff[j]};
                     arow = sat_add(alloc_p_ff[j], amt_ff[j]);
                  end else begin
                     avail_in[j] = sat_add(avail_ff[j], amt_ff[j]);
                     nrow = sat_add(need_p_ff[j], amt_ff[j]);
                     arow = alloc_p_ff[j] - {2'b00, amt_ff[j]};
                  end
               end
               need_wr_data[j*VAL_W +: VAL_W]  = nrow;
               alloc_wr_data[j*VAL_W +: VAL_W] = arow;
            end
            granted_in = 1'b1;
            status_in  = ST_OK;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         comp_ff  <= '0;
         ar_ff    <= 3'd4;
         ap_ff    <= '0;
         for (int j = 0; j < NUM_RES; j++) begin
            avail_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         ar_ff    <= ar_in;
         ap_ff    <= ap_in;
         avail_ff <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      p_ff        <= p_in;
      amt_ff      <= amt_in;
      need_p_ff   <= need_p_in;
      alloc_p_ff  <= alloc_p_in;
      tn_need_ff  <= tn_need_in;
      tn_alloc_ff <= tn_alloc_in;
      work_ff     <= work_in;
      fin_ff      <= fin_in;
      scan_ff     <= scan_in;
      prog_ff     <= prog_in;
      granted_ff  <= granted_in;
      status_ff   <= status_in;
   end

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CHK))
      else $error("accepted beat did not start checking");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      (need_wr_en || alloc_wr_en) |-> (state_ff == S_CHK || state_ff == S_COMMIT))
      else $error("table write outside check or commit");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRD || state_ff == S_SEV) |-> (scan8 <= np8))
      else $error("scan index past active processes");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && granted_ff) |-> (status_ff == ST_OK))
      else $error("grant with nonzero status");
`endif

endmodule
